### rtl/ppz_pkg.sv
// Shared widths, codes, types and defaults for the point projector and plotter.
`default_nettype none
package ppz_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned PIXELS_DEF = 8192;
  localparam int unsigned FOCAL_DEF  = 40;
  localparam int unsigned CAM_DEF    = 60;

  // Operation codes carried in tuser.
  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SIN_A  = 3'd0;
  localparam logic [2:0] REG_COS_A  = 3'd1;
  localparam logic [2:0] REG_SIN_B  = 3'd2;
  localparam logic [2:0] REG_COS_B  = 3'd3;
  localparam logic [2:0] REG_SIN_C  = 3'd4;
  localparam logic [2:0] REG_COS_C  = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  // Datapath widths.
  localparam int COEF_W      = 20;          // rotation coefficients, Q14
  localparam int ACC_W       = 2 * COEF_W;  // rotated coordinates, Q22
  localparam int QF          = 14;          // fraction bits of a coefficient
  localparam int ZQF         = 22;          // fraction bits of a rotated coordinate
  localparam int RECIP_SHIFT = 46;          // reciprocal is 2^46 / z
  localparam int DIVD_W      = RECIP_SHIFT + 1;
  localparam int DIVS_W      = 37;          // positive depth fits here
  localparam int NUM_W       = 48;          // scaled projection numerators
  localparam int IW          = 49;          // projected column and row
  localparam int IDX_W       = IW + 10;     // frame index before range check
  localparam int DEPTH_W     = 24;
  localparam int GLYPH_W     = 8;
  localparam int WORD_W      = DEPTH_W + GLYPH_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 24'hFF_FFFF;
  localparam logic [GLYPH_W-1:0] SPACE_CODE = 8'd32;

  typedef struct packed {
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_b;
    logic signed [15:0] cos_b;
    logic signed [15:0] sin_c;
    logic signed [15:0] cos_c;
  } rot_cfg_t;

endpackage
`default_nettype wire

### rtl/ppz_rot.sv
// Rotation unit: forms the rotation matrix and rotates one point on a shared multiplier.
`default_nettype none
module ppz_rot #(
  parameter int unsigned CAMERA_DISTANCE = ppz_pkg::CAM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  ppz_pkg::rot_cfg_t                  cfg,
  input  logic signed [15:0]                 pnt_x,
  input  logic signed [15:0]                 pnt_y,
  input  logic signed [15:0]                 pnt_z,
  output logic                               done,
  output logic signed [ppz_pkg::ACC_W-1:0]   x,
  output logic signed [ppz_pkg::ACC_W-1:0]   y,
  output logic signed [ppz_pkg::ACC_W-1:0]   z
);
  import ppz_pkg::*;

  typedef enum logic [4:0] {
    M_SASB, M_CASB, M_XI, M_XJ0, M_XJ1, M_XK0, M_XK1, M_YI, M_YJ0, M_YJ1,
    M_YK0, M_YK1, M_ZJ, M_ZK, M_X0, M_X1, M_X2, M_Y0, M_Y1, M_Y2, M_Z0, M_Z1, M_Z2
  } step_t;

  localparam logic signed [ACC_W-1:0] CAM_Q = ACC_W'(CAMERA_DISTANCE) <<< ZQF;
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< (QF - 1);

  step_t step, step_d;
  logic  busy, pv;
  logic signed [COEF_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0]  prod, rsum;
  logic signed [COEF_W-1:0] q;
  logic signed [COEF_W-1:0] sasb, casb, xi, xj, xk, yi, yj, yk, zj, zk;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      M_SASB: begin op_a = COEF_W'(cfg.sin_a); op_b = COEF_W'(cfg.sin_b); end
      M_CASB: begin op_a = COEF_W'(cfg.cos_a); op_b = COEF_W'(cfg.sin_b); end
      M_XI:   begin op_a = COEF_W'(cfg.cos_b); op_b = COEF_W'(cfg.cos_c); end
      M_XJ0:  begin op_a = sasb;               op_b = COEF_W'(cfg.cos_c); end
      M_XJ1:  begin op_a = COEF_W'(cfg.cos_a); op_b = COEF_W'(cfg.sin_c); end
      M_XK0:  begin op_a = COEF_W'(cfg.sin_a); op_b = COEF_W'(cfg.sin_c); end
      M_XK1:  begin op_a = casb;               op_b = COEF_W'(cfg.cos_c); end
      M_YI:   begin op_a = COEF_W'(cfg.cos_b); op_b = COEF_W'(cfg.sin_c); end
      M_YJ0:  begin op_a = COEF_W'(cfg.cos_a); op_b = COEF_W'(cfg.cos_c); end
      M_YJ1:  begin op_a = sasb;               op_b = COEF_W'(cfg.sin_c); end
      M_YK0:  begin op_a = COEF_W'(cfg.sin_a); op_b = COEF_W'(cfg.cos_c); end
      M_YK1:  begin op_a = casb;               op_b = COEF_W'(cfg.sin_c); end
      M_ZJ:   begin op_a = COEF_W'(cfg.sin_a); op_b = COEF_W'(cfg.cos_b); end
      M_ZK:   begin op_a = COEF_W'(cfg.cos_a); op_b = COEF_W'(cfg.cos_b); end
      M_X0:   begin op_a = COEF_W'(pnt_x);     op_b = xi; end
      M_X1:   begin op_a = COEF_W'(pnt_y);     op_b = xj; end
      M_X2:   begin op_a = COEF_W'(pnt_z);     op_b = xk; end
      M_Y0:   begin op_a = COEF_W'(pnt_x);     op_b = yi; end
      M_Y1:   begin op_a = COEF_W'(pnt_y);     op_b = yj; end
      M_Y2:   begin op_a = COEF_W'(pnt_z);     op_b = yk; end
      M_Z0:   begin op_a = COEF_W'(pnt_x);     op_b = COEF_W'(cfg.sin_b); end
      M_Z1:   begin op_a = COEF_W'(pnt_y);     op_b = zj; end
      M_Z2:   begin op_a = COEF_W'(pnt_z);     op_b = zk; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Round a Q28 product back to Q14, ties toward plus infinity.
  assign rsum = prod + RND;
  assign q    = COEF_W'(rsum >>> QF);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      step <= M_SASB;
    end else begin
      done <= 1'b0;
      pv   <= busy;
      if (start) begin
        busy <= 1'b1;
        step <= M_SASB;
      end else if (busy) begin
        if (step == M_Z2) begin
          busy <= 1'b0;
        end else begin
          step <= step_t'(step + 5'd1);
        end
      end
      if (pv && step_d == M_Z2) begin
        done <= 1'b1;
      end
    end
    if (busy) begin
      prod   <= op_a * op_b;
      step_d <= step;
    end
    if (pv) begin
      case (step_d)
        M_SASB: sasb <= q;
        M_CASB: casb <= q;
        M_XI:   xi   <= q;
        M_XJ0:  xj   <= q;
        M_XJ1:  xj   <= xj + q;
        M_XK0:  xk   <= q;
        M_XK1:  xk   <= xk - q;
        M_YI:   yi   <= -q;
        M_YJ0:  yj   <= q;
        M_YJ1:  yj   <= yj - q;
        M_YK0:  yk   <= q;
        M_YK1:  yk   <= yk + q;
        M_ZJ:   zj   <= -q;
        M_ZK:   zk   <= q;
        M_X0:   x    <= prod;
        M_X1:   x    <= x + prod;
        M_X2:   x    <= x + prod;
        M_Y0:   y    <= prod;
        M_Y1:   y    <= y + prod;
        M_Y2:   y    <= y + prod;
        M_Z0:   z    <= prod + CAM_Q;
        M_Z1:   z    <= z + prod;
        M_Z2:   z    <= z + prod;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/ppz_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module ppz_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppz_pkg::DIVD_W-1:0]    dividend,
  input  logic [ppz_pkg::DIVS_W-1:0]    divisor,
  output logic                          done,
  output logic [ppz_pkg::DIVD_W-1:0]    quotient,
  output logic [ppz_pkg::DIVS_W-1:0]    remainder
);
  import ppz_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign trial = {remainder, quotient[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      remainder <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quotient  <= {quotient[DIVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### rtl/point_project_zbuffer_plotter.sv
// Top level: point projector with a depth-buffered character frame store.
`default_nettype none
// Takes one word at a time. tuser carries the operation: plot a point, clear the frame,
// read one glyph (any other code: zero result). A plot rotates the Q7.8 point by the three
// angles held as Q1.14 sine/cosine registers, pushes it out by CAMERA_DISTANCE, projects it
// with twice the focal length across and once down (truncating toward zero), and stores the
// glyph when the index lies in the frame and the Q0.24 reciprocal depth beats the stored
// one. Every operation returns exactly one result word. Depth and glyph share one
// synchronous store of PIXELS words with a registered read; a plot reads the entry,
// compares and writes back before the next word is taken, so accesses never overlap.
// A plot runs the 23-step rotation on one shared multiplier, then three passes of the
// bit-serial divider (reciprocal, column, row); a discarded point (depth zero or less)
// skips the divider and goes straight to its result word.
// A clear writes all PIXELS entries, one entry a cycle; the same pass runs after
// reset, and no word is taken until it ends (configuration writes are taken throughout).
module point_project_zbuffer_plotter #(
  parameter int unsigned PIXELS          = ppz_pkg::PIXELS_DEF,
  parameter int unsigned FOCAL           = ppz_pkg::FOCAL_DEF,
  parameter int unsigned CAMERA_DISTANCE = ppz_pkg::CAM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x[15:0], point_y[31:16], point_z[47:32], column_shift[56:48],
  // glyph[64:57], pixel_index[77:65], zero pad [79:78]
  input  logic [79:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // plotted[0], plot_index[13:1], read_glyph[21:14], zero pad [23:22]
  output logic [23:0] m_axis_tdata,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ppz_pkg::*;

  localparam int AW = $clog2(PIXELS);
  localparam logic signed [NUM_W-1:0] FOC2 = NUM_W'(2 * FOCAL);
  localparam logic signed [NUM_W-1:0] FOC1 = NUM_W'(FOCAL);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROT, S_ZCHK, S_RECIP, S_COL, S_ROW, S_MUL, S_IDX, S_CMP,
    S_RDATA, S_POST
  } state_t;

  // Configuration registers
  rot_cfg_t   cfg;
  logic [7:0] scr_w;
  logic [5:0] scr_h;

  // Input fields as seen on the bus
  logic signed [15:0] in_x, in_y, in_z;
  logic signed [8:0]  in_shift;
  logic [7:0]         in_glyph;
  logic [12:0]        in_pidx;

  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign in_z     = s_axis_tdata[47:32];
  assign in_shift = s_axis_tdata[56:48];
  assign in_glyph = s_axis_tdata[64:57];
  assign in_pidx  = s_axis_tdata[77:65];

  // Held copy of the accepted word
  logic signed [15:0] pnt_x, pnt_y, pnt_z;
  logic signed [8:0]  col_shift;
  logic [7:0]         glyph_in;
  logic               rd_ok;

  state_t state;
  logic   clr_post;
  logic [AW-1:0] clr_cnt;

  // Rotation and divider hookup
  logic rot_start, rot_done;
  logic signed [ACC_W-1:0] rx, ry, rz;
  logic div_start, div_done;
  logic [DIVD_W-1:0] div_dvd, div_quo;
  logic [DIVS_W-1:0] div_dvs, div_rem;

  // Projection datapath
  logic signed [NUM_W-1:0] bx, by;
  logic [NUM_W-1:0]        bx_abs, by_abs;
  logic [DEPTH_W-1:0]      ooz;
  logic signed [IW-1:0]    col, row, col_base, row_base, col_v, row_v;
  logic signed [IDX_W-1:0] rowprod, idx_v;
  logic [13:0]             frame_sz;
  logic                    idx_ok;
  logic [AW-1:0]           idx_addr;

  // Results
  logic        res_plotted;
  logic [12:0] res_index;
  logic [7:0]  res_glyph;

  // Frame store: glyph in the upper byte, reciprocal depth below
  logic [WORD_W-1:0] mem [PIXELS];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     raddr, waddr;
  logic [WORD_W-1:0] wdata;
  logic              mem_we;
  logic              nearer;

  // Turn a floor quotient (magnitude q0, sign neg, nonzero remainder nz) plus base into
  // the truncated quotient of (base*z + b)/z.
  function automatic logic signed [IW-1:0] trunc_sum(input logic [DIVD_W-1:0] q0,
                                                     input logic nz, input logic neg,
                                                     input logic signed [IW-1:0] base);
    logic signed [IW-1:0] qf;
    logic signed [IW-1:0] s;
    qf = $signed(IW'(q0));
    if (neg) begin
      qf = -qf;
      if (nz) qf = qf - IW'(1);
    end
    s = base + qf;
    if (s < 0 && nz) s = s + IW'(1);
    return s;
  endfunction

  ppz_rot #(
    .CAMERA_DISTANCE(CAMERA_DISTANCE)
  ) u_rot (
    .clk   (clk),
    .rst   (rst),
    .start (rot_start),
    .cfg   (cfg),
    .pnt_x (pnt_x),
    .pnt_y (pnt_y),
    .pnt_z (pnt_z),
    .done  (rot_done),
    .x     (rx),
    .y     (ry),
    .z     (rz)
  );

  ppz_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_a <= 16'sd0;
      cfg.cos_a <= 16'sd16384;
      cfg.sin_b <= 16'sd0;
      cfg.cos_b <= 16'sd16384;
      cfg.sin_c <= 16'sd0;
      cfg.cos_c <= 16'sd16384;
      scr_w     <= 8'd60;
      scr_h     <= 6'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIN_A:  cfg.sin_a <= cfg_data;
        REG_COS_A:  cfg.cos_a <= cfg_data;
        REG_SIN_B:  cfg.sin_b <= cfg_data;
        REG_COS_B:  cfg.cos_b <= cfg_data;
        REG_SIN_C:  cfg.sin_c <= cfg_data;
        REG_COS_C:  cfg.cos_c <= cfg_data;
        REG_WIDTH:  scr_w     <= cfg_data[7:0];
        REG_HEIGHT: scr_h     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign bx_abs   = bx[NUM_W-1] ? NUM_W'(-bx) : NUM_W'(bx);
  assign by_abs   = by[NUM_W-1] ? NUM_W'(-by) : NUM_W'(by);
  assign col_base = IW'($signed({1'b0, scr_w[7:1]})) + IW'(col_shift);
  assign row_base = IW'($signed({1'b0, scr_h[5:1]}));
  assign col_v    = trunc_sum(div_quo, div_rem != '0, bx[NUM_W-1], col_base);
  assign row_v    = trunc_sum(div_quo, div_rem != '0, by[NUM_W-1], row_base);
  assign frame_sz = 14'(scr_w * scr_h);
  assign idx_v    = IDX_W'(col) + rowprod;
  assign idx_ok   = (idx_v >= 0) && (idx_v < IDX_W'($signed({1'b0, frame_sz})))
                    && (idx_v < IDX_W'(PIXELS));
  assign nearer   = ooz > rd_data[DEPTH_W-1:0];

  assign s_axis_tready = (state == S_IDLE);

  // Store access: the read address follows the bus while idle, else the plot index.
  always_comb begin
    raddr  = (state == S_IDLE) ? AW'(in_pidx) : AW'(idx_v);
    mem_we = 1'b0;
    waddr  = idx_addr;
    wdata  = {glyph_in, ooz};
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_cnt;
        wdata  = {SPACE_CODE, DEPTH_W'(0)};
      end
      S_CMP: mem_we = nearer;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      clr_post      <= 1'b0;
      rot_start     <= 1'b0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rot_start <= 1'b0;
      div_start <= 1'b0;
      // Drop valid once taken; the post state reloads it on its own.
      if (m_axis_tvalid && m_axis_tready && state != S_POST) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(PIXELS - 1)) begin
            state <= clr_post ? S_POST : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pnt_x       <= in_x;
            pnt_y       <= in_y;
            pnt_z       <= in_z;
            col_shift   <= in_shift;
            glyph_in    <= in_glyph;
            rd_ok       <= 32'(in_pidx) < PIXELS;
            res_plotted <= 1'b0;
            res_index   <= '0;
            res_glyph   <= '0;
            case (s_axis_tuser)
              OP_PLOT: begin
                rot_start <= 1'b1;
                state     <= S_ROT;
              end
              OP_CLEAR: begin
                clr_cnt  <= '0;
                clr_post <= 1'b1;
                state    <= S_CLEAR;
              end
              OP_READ: state <= S_RDATA;
              default: state <= S_POST;
            endcase
          end
        end
        S_ROT: begin
          if (rot_done) state <= S_ZCHK;
        end
        S_ZCHK: begin
          // Drop points at or behind the eye; start the reciprocal otherwise.
          if (rz <= 0) begin
            state <= S_POST;
          end else begin
            bx        <= NUM_W'(rx) * FOC2;
            by        <= NUM_W'(ry) * FOC1;
            div_dvd   <= DIVD_W'(1) << RECIP_SHIFT;
            div_dvs   <= DIVS_W'(rz);
            div_start <= 1'b1;
            state     <= S_RECIP;
          end
        end
        S_RECIP: begin
          if (div_done) begin
            ooz       <= (div_quo > DIVD_W'(DEPTH_MAX)) ? DEPTH_MAX : div_quo[DEPTH_W-1:0];
            div_dvd   <= DIVD_W'(bx_abs);
            div_start <= 1'b1;
            state     <= S_COL;
          end
        end
        S_COL: begin
          if (div_done) begin
            col       <= col_v;
            div_dvd   <= DIVD_W'(by_abs);
            div_start <= 1'b1;
            state     <= S_ROW;
          end
        end
        S_ROW: begin
          if (div_done) begin
            row   <= row_v;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          rowprod <= IDX_W'(row) * IDX_W'($signed({1'b0, scr_w}));
          state   <= S_IDX;
        end
        S_IDX: begin
          // The store read at this index is issued in this cycle.
          idx_addr <= AW'(idx_v);
          if (idx_ok) begin
            res_index <= 13'(idx_v);
            state     <= S_CMP;
          end else begin
            state <= S_POST;
          end
        end
        S_CMP: begin
          res_plotted <= nearer;
          state       <= S_POST;
        end
        S_RDATA: begin
          res_glyph <= rd_ok ? rd_data[WORD_W-1:DEPTH_W] : '0;
          state     <= S_POST;
        end
        S_POST: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, res_glyph, res_index, res_plotted};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rot_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    rot_done |-> state == S_ROT)
    else $error("rotation finished outside its wait state");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_RECIP || state == S_COL || state == S_ROW))
    else $error("divider finished outside a divide state");

  a_cmp_then_post: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |=> state == S_POST)
    else $error("depth compare not followed by result post");
`endif

endmodule
`default_nettype wire
